// ===== rtl/core/tld_pkg.sv =====
// tld_pkg: item types, character codes, result kinds and the
// controller/datapath command and status bundles of the terminal line discipline.
// No dependencies.
`timescale 1ns / 1ps

package tld_pkg;

    localparam logic       CMD_KEY  = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    localparam logic [7:0] EOL_MARK  = 8'h80;
    localparam logic [7:0] KEY_ESC   = 8'h5C;
    localparam logic [7:0] KEY_CR    = 8'h0D;
    localparam logic [7:0] KEY_LF    = 8'h0A;
    localparam logic [7:0] KEY_BS    = 8'h08;

    localparam int         COUNT_W   = 16;
    localparam int         NRES_W    = 7;
    // drain stops once this many results were given for one item
    localparam logic [NRES_W-1:0] RES_LIMIT = 7'd63;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         key_char;
        logic [COUNT_W-1:0] read_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] data_char;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic take;       // latch the accepted item
        logic apply;      // apply the key or read request
        logic emit_drop;  // give the store-full result
        logic mem_rd;     // read the oldest entry
        logic emit_char;  // deliver the entry read
        logic emit_mark;  // consume end-of-line, give completion
        logic emit_done;  // give completion after count ran out
    } tld_cmd_t;

    typedef struct packed {
        logic is_drop;    // latched key meets a full store
        logic can_drain;  // reader pending, data stored, limit not hit
        logic is_mark;    // entry read carries the end-of-line mark
        logic count_one;  // reader wants exactly one more
        logic out_free;   // output register can take a result
    } tld_stat_t;

endpackage

// ===== rtl/core/tld_ctrl.sv =====
// tld_ctrl: sequencer of the terminal line discipline.
// Steps one item through key handling and the drain loop. Uses tld_pkg.
`timescale 1ns / 1ps

module tld_ctrl
    import tld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tld_stat_t stat,
    output tld_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_CHECK,
        S_EMIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_KEY:
            begin
                // a dropped key needs the output register
                if (!stat.is_drop || stat.out_free)
                begin
                    cmd.apply     = 1'b1;
                    cmd.emit_drop = stat.is_drop;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.can_drain)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.is_mark)
                    begin
                        cmd.emit_mark = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_char = 1'b1;
                        state_next    = stat.count_one ? S_DONE : S_CHECK;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/tld_dp.sv =====
// tld_dp: datapath of the terminal line discipline: ring store, indices,
// fill and pending counts, escape flag and the output register. Uses tld_pkg.
`timescale 1ns / 1ps

module tld_dp
    import tld_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  tld_cmd_t  cmd,
    output tld_stat_t stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(STORE_DEPTH);

    logic [7:0] store_mem [STORE_DEPTH];

    in_item_t           item_reg;
    logic [7:0]         rdata_reg;
    logic               esc_reg,  esc_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [COUNT_W-1:0] pend_reg, pend_next;
    logic [NRES_W-1:0]  nres_reg, nres_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg,  out_item_next;

    logic       store_key;
    logic       erase_key;
    logic       esc_key;
    logic [6:0] key_byte;
    logic [7:0] store_byte;
    logic       full;
    logic       out_free;
    logic       char_last;
    logic [AW-1:0] head_inc, head_dec, tail_inc;

    assign full     = (fill_reg == FULL_CNT);
    assign out_free = !out_valid_reg || out_ready;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    // key decode of the latched item
    always_comb
    begin
        store_key = 1'b0;
        erase_key = 1'b0;
        esc_key   = 1'b0;
        key_byte  = item_reg.key_char[6:0];
        if (item_reg.cmd == CMD_KEY)
        begin
            if (esc_reg)
            begin
                store_key = 1'b1;
            end
            else if (item_reg.key_char == KEY_ESC)
            begin
                esc_key = 1'b1;
            end
            else if (item_reg.key_char == KEY_CR)
            begin
                store_key = 1'b1;
                key_byte  = KEY_LF[6:0];
            end
            else if (item_reg.key_char == KEY_BS)
            begin
                erase_key = 1'b1;
            end
            else
            begin
                store_key = 1'b1;
            end
        end
    end

    // only LF carries the end-of-line mark
    assign store_byte = (key_byte == KEY_LF[6:0]) ? (EOL_MARK | {1'b0, key_byte})
                                                  : {1'b0, key_byte};

    // a character is last when the count stays open and the loop ends here
    assign char_last = (pend_reg != COUNT_W'(1))
                    && ((fill_reg == FW'(1)) || (nres_reg >= RES_LIMIT - 1'b1));

    assign stat.is_drop   = store_key && full;
    assign stat.can_drain = (pend_reg != '0) && (fill_reg != '0) && (nres_reg < RES_LIMIT);
    assign stat.is_mark   = rdata_reg[7];
    assign stat.count_one = (pend_reg == COUNT_W'(1));
    assign stat.out_free  = out_free;

    always_comb
    begin
        esc_next       = esc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        nres_next      = nres_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        if (cmd.take)
        begin
            nres_next = '0;
        end

        if (cmd.apply)
        begin
            if (item_reg.cmd == CMD_READ)
            begin
                if (item_reg.read_count != '0)
                begin
                    pend_next = item_reg.read_count;
                end
            end
            else
            begin
                esc_next = esc_key;
                if (erase_key && (fill_reg != '0))
                begin
                    head_next = head_dec;
                    fill_next = fill_reg - 1'b1;
                end
                if (store_key && !full)
                begin
                    head_next = head_inc;
                    fill_next = fill_reg + 1'b1;
                end
            end
        end

        if (cmd.emit_drop)
        begin
            out_valid_next = 1'b1;
            out_item_next  = '{kind: KIND_DROP, data_char: 7'd0, last: (pend_reg == '0)};
            nres_next      = nres_reg + 1'b1;
        end

        if (cmd.emit_char)
        begin
            out_valid_next = 1'b1;
            out_item_next  = '{kind: KIND_CHAR, data_char: rdata_reg[6:0], last: char_last};
            tail_next      = tail_inc;
            fill_next      = fill_reg - 1'b1;
            pend_next      = pend_reg - 1'b1;
            nres_next      = nres_reg + 1'b1;
        end

        if (cmd.emit_mark)
        begin
            // consume the mark, deliver nothing of it
            out_valid_next = 1'b1;
            out_item_next  = '{kind: KIND_DONE, data_char: 7'd0, last: 1'b1};
            tail_next      = tail_inc;
            fill_next      = fill_reg - 1'b1;
            pend_next      = '0;
            nres_next      = nres_reg + 1'b1;
        end

        if (cmd.emit_done)
        begin
            out_valid_next = 1'b1;
            out_item_next  = '{kind: KIND_DONE, data_char: 7'd0, last: 1'b1};
            nres_next      = nres_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= '0;
            nres_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            esc_reg       <= esc_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            nres_reg      <= nres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (cmd.take)
        begin
            item_reg <= in_data;
        end
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.apply && store_key && !full)
        begin
            store_mem[head_reg] <= store_byte;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= store_mem[tail_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// ===== rtl/core/terminal_line_discipline.sv =====
// Terminal line discipline: key bytes into a ring store, lines out to a reader.
// An item is latched, then applied; a read then drains the store, each character read
// from the single read port of the ring store and then emitted, until the count runs
// out, an end-of-line mark completes the read, the store empties or the result limit
// is hit. Every result can be held while the output stalls. One item at a time.
// Reset clears indices, counts and the escape flag; store stays undefined.
`timescale 1ns / 1ps

module terminal_line_discipline
    import tld_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    tld_cmd_t  cmd;
    tld_stat_t stat;

    tld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tld_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block took a new item while busy");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_DONE) |-> out_data.last)
        else $error("read completion not marked last");

    a_no_char_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != KIND_CHAR) |-> (out_data.data_char == 7'd0))
        else $error("non-character result carries data");

endmodule
